### rtl/slcd_pkg.sv
// Shared types and codes for the sync/length/checksum deframer.
// Holds parser phase codes, result kinds, register indexes and reset values.
// No dependencies.
`default_nettype none

package slcd_pkg;

	// Byte and field types
	typedef logic [7:0] byte_t;
	typedef logic [2:0] phase_t;
	typedef logic [1:0] kind_t;
	typedef logic [0:0] cfg_idx_t;

	// Parser phases
	localparam phase_t PH_SYNC1   = 3'd0;
	localparam phase_t PH_SYNC2   = 3'd1;
	localparam phase_t PH_LENGTH  = 3'd2;
	localparam phase_t PH_PAYLOAD = 3'd3;
	localparam phase_t PH_CHECK   = 3'd4;
	localparam phase_t PH_STOPPED = 3'd5;

	// Result kinds
	localparam kind_t KIND_PAYLOAD = 2'd0;
	localparam kind_t KIND_GOOD    = 2'd1;
	localparam kind_t KIND_BADSUM  = 2'd2;
	localparam kind_t KIND_TOOLONG = 2'd3;

	// Configuration register indexes
	localparam cfg_idx_t REG_SYNC_VALUE   = 1'd0;
	localparam cfg_idx_t REG_LENGTH_LIMIT = 1'd1;

	// Reset values of the configuration registers
	localparam byte_t SYNC_VALUE_RST   = 8'd170;
	localparam byte_t LENGTH_LIMIT_RST = 8'd170;

endpackage

`default_nettype wire

### rtl/sync_length_checksum_deframer.sv
// Channel   | handshake            | payload
// ----------+----------------------+---------------------------------
// in        | in_valid / in_ready  | in_byte[7:0]
// out       | out_valid / out_ready| kind[1:0], data[7:0], frame_end
// cfg       | cfg_valid / cfg_ready| cfg_index[0:0], cfg_data[7:0]
//
// One byte is taken per cycle; its result, if any, appears in the output
// register on the following cycle. The output register alone sets the pace:
// in_ready is high whenever that register is empty or being emptied.
// Reset clears the parser to hunting the first sync byte and loads both
// registers with 170. A too-long length stops the parser until reset.
// cfg_ready is always high; a write takes effect on the next byte.
//
// Top level of the deframer: parser state, running sum and result register.
// Depends on slcd_pkg.
`default_nettype none

module sync_length_checksum_deframer (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire  [7:0]               in_byte,
	output logic                     out_valid,
	input  wire                      out_ready,
	output logic [1:0]               kind,
	output logic [7:0]               data,
	output logic                     frame_end,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire  [0:0]               cfg_index,
	input  wire  [7:0]               cfg_data
);

	slcd_pkg::byte_t  sync_value_q;
	slcd_pkg::byte_t  length_limit_q;
	slcd_pkg::phase_t phase_q;
	slcd_pkg::byte_t  bytes_left_q;
	slcd_pkg::byte_t  running_sum_q;

	logic             out_valid_q;
	slcd_pkg::kind_t  kind_q;
	slcd_pkg::byte_t  data_q;
	logic             frame_end_q;

	logic             in_fire;
	slcd_pkg::phase_t phase_d;
	slcd_pkg::byte_t  bytes_left_d;
	slcd_pkg::byte_t  running_sum_d;
	logic             emit;
	slcd_pkg::kind_t  kind_d;
	logic             frame_end_d;

	// Accept while the result register is empty or being taken
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign frame_end = frame_end_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q   <= slcd_pkg::SYNC_VALUE_RST;
			length_limit_q <= slcd_pkg::LENGTH_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				slcd_pkg::REG_SYNC_VALUE:   sync_value_q   <= cfg_data;
				slcd_pkg::REG_LENGTH_LIMIT: length_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next parser state and result for the byte at the input
	always_comb begin
		phase_d       = phase_q;
		bytes_left_d  = bytes_left_q;
		running_sum_d = running_sum_q;
		emit          = 1'b0;
		kind_d        = slcd_pkg::KIND_PAYLOAD;
		frame_end_d   = 1'b0;
		case (phase_q)
			slcd_pkg::PH_SYNC1: begin
				if (in_byte == sync_value_q) phase_d = slcd_pkg::PH_SYNC2;
			end
			slcd_pkg::PH_SYNC2: begin
				phase_d = (in_byte == sync_value_q) ? slcd_pkg::PH_LENGTH
				                                    : slcd_pkg::PH_SYNC1;
			end
			slcd_pkg::PH_LENGTH: begin
				if (in_byte >= length_limit_q) begin
					phase_d     = slcd_pkg::PH_STOPPED;
					emit        = 1'b1;
					kind_d      = slcd_pkg::KIND_TOOLONG;
					frame_end_d = 1'b1;
				end else begin
					bytes_left_d  = in_byte;
					running_sum_d = 8'd0;
					phase_d = (in_byte == 8'd0) ? slcd_pkg::PH_CHECK
					                            : slcd_pkg::PH_PAYLOAD;
				end
			end
			slcd_pkg::PH_PAYLOAD: begin
				running_sum_d = running_sum_q + in_byte;
				bytes_left_d  = bytes_left_q - 8'd1;
				if (bytes_left_q == 8'd1) phase_d = slcd_pkg::PH_CHECK;
				emit = 1'b1;
			end
			slcd_pkg::PH_CHECK: begin
				phase_d       = slcd_pkg::PH_SYNC1;
				bytes_left_d  = 8'd0;
				running_sum_d = 8'd0;
				emit          = 1'b1;
				kind_d = (in_byte == ~running_sum_q) ? slcd_pkg::KIND_GOOD
				                                     : slcd_pkg::KIND_BADSUM;
				frame_end_d   = 1'b1;
			end
			default: begin
				phase_d = slcd_pkg::PH_STOPPED;
			end
		endcase
	end

	// Parser state: advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= slcd_pkg::PH_SYNC1;
			bytes_left_q  <= 8'd0;
			running_sum_q <= 8'd0;
		end else if (in_fire) begin
			phase_q       <= phase_d;
			bytes_left_q  <= bytes_left_d;
			running_sum_q <= running_sum_d;
		end
	end

	// Result register: load on a producing item, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			kind_q      <= kind_d;
			data_q      <= in_byte;
			frame_end_q <= frame_end_d;
		end
	end

`ifndef SYNTHESIS
	// A stopped parser never restarts
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == slcd_pkg::PH_STOPPED |=> phase_q == slcd_pkg::PH_STOPPED)
		else $error("parser left the stopped phase");

	// Frame end marks exactly the non-payload results
	a_end_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (frame_end_q == (kind_q != slcd_pkg::KIND_PAYLOAD)))
		else $error("frame_end disagrees with kind");

	// Payload phase always has bytes still to come
	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == slcd_pkg::PH_PAYLOAD |-> bytes_left_q != 8'd0)
		else $error("payload phase with zero bytes left");

	// Once stopped, a taken result is not followed by another
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == slcd_pkg::PH_STOPPED && out_valid_q && out_ready)
		|=> !out_valid_q)
		else $error("result produced while stopped");

	// An empty result register never stalls the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire
